FILE: hw/rtl/pptmr_pkg.sv
// pptmr_pkg: shared types, constants and helpers for the phase timer
// used by pptmr_cfg and pomodoro_phase_timer; no dependencies
package pptmr_pkg;

  localparam int TIME_BITS = 16;
  localparam int CLIP_W    = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int OUT16_MAX = 65535;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    REG_WORK_MIN  = 3'd0,
    REG_SHORT_MIN = 3'd1,
    REG_LONG_MIN  = 3'd2,
    REG_LONG_AFT  = 3'd3,
    REG_LOCAL     = 3'd4
  } reg_idx_t;

  localparam logic [7:0] WORK_MIN_RST  = 8'd25;
  localparam logic [7:0] SHORT_MIN_RST = 8'd5;
  localparam logic [7:0] LONG_MIN_RST  = 8'd15;
  localparam logic [3:0] LONG_AFT_RST  = 4'd4;
  localparam logic       LOCAL_RST     = 1'b1;

  typedef struct packed {
    logic [7:0] work_min;
    logic [7:0] short_min;
    logic [7:0] long_min;
    logic [3:0] long_after;
    logic       local_mode;
  } cfg_t;

  // minutes to seconds: m*64 - m*4
  function automatic time_t min_to_sec(input logic [7:0] mins);
    logic [13:0] m;
    m = 14'(mins);
    return time_t'((m << 6) - (m << 2));
  endfunction

  function automatic logic [15:0] clip16(input time_t v);
    logic [CLIP_W-1:0] wv;
    wv = CLIP_W'(v);
    return (wv > CLIP_W'(OUT16_MAX)) ? 16'hFFFF : wv[15:0];
  endfunction

endpackage

FILE: hw/rtl/pptmr_cfg.sv
// pptmr_cfg: apb-style configuration registers of the phase timer
// depends on pptmr_pkg
module pptmr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pptmr_pkg::ADDR_W-1:0]   paddr,
  input  logic [pptmr_pkg::DATA_W-1:0]   pwdata,
  output logic [pptmr_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output pptmr_pkg::cfg_t                cfg
);
  import pptmr_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WORK_MIN:  if (pwdata[7:0] != 8'd0) cfg_nxt.work_min = pwdata[7:0];
        REG_SHORT_MIN: if (pwdata[7:0] != 8'd0) cfg_nxt.short_min = pwdata[7:0];
        REG_LONG_MIN:  if (pwdata[7:0] != 8'd0) cfg_nxt.long_min = pwdata[7:0];
        REG_LONG_AFT:  if (pwdata[3:0] != 4'd0) cfg_nxt.long_after = pwdata[3:0];
        REG_LOCAL:     cfg_nxt.local_mode = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WORK_MIN:  prdata = DATA_W'(cfg_r.work_min);
      REG_SHORT_MIN: prdata = DATA_W'(cfg_r.short_min);
      REG_LONG_MIN:  prdata = DATA_W'(cfg_r.long_min);
      REG_LONG_AFT:  prdata = DATA_W'(cfg_r.long_after);
      REG_LOCAL:     prdata = DATA_W'(cfg_r.local_mode);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.work_min   <= WORK_MIN_RST;
      cfg_r.short_min  <= SHORT_MIN_RST;
      cfg_r.long_min   <= LONG_MIN_RST;
      cfg_r.long_after <= LONG_AFT_RST;
      cfg_r.local_mode <= LOCAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/pomodoro_phase_timer.sv
// pomodoro_phase_timer: top level of the work/break countdown sequencer
// depends on pptmr_pkg and pptmr_cfg
//
// usage: each input word is one event (tick, toggle, skip, reset, extend)
// on in_valid/in_ready; each event yields exactly one result word on
// out_valid/out_ready with the run state, phase, remaining seconds, work
// count and a completion report. phase lengths and cadence are set through
// the apb-style port (psel/penable/pwrite/paddr/pwdata/prdata/pready).
// an accepted event passes the input register, then one pass of update
// logic into the result register, which also holds the timer state update;
// out_valid rises when the result register loads. throughput: one event per
// cycle while out_ready stays high, set by the single state update path.
// when the receiver stalls the result register holds, the input register
// fills, and in_ready drops only when both are full.
// reset (rst_n, synchronous) loads register defaults, stops the timer in
// the work phase at 1500 seconds and clears the work count.
module pomodoro_phase_timer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_req_type,
  input  logic [15:0]                    in_extend_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_run_state,
  output logic [1:0]                     out_phase_now,
  output logic [15:0]                    out_seconds_shown,
  output logic [15:0]                    out_work_done_count,
  output logic                           out_phase_finished,
  output logic [1:0]                     out_finished_phase,
  output logic [15:0]                    out_finished_seconds,
  output logic                           out_finished_was_work,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pptmr_pkg::ADDR_W-1:0]   paddr,
  input  logic [pptmr_pkg::DATA_W-1:0]   pwdata,
  output logic [pptmr_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import pptmr_pkg::*;

  typedef enum logic [1:0] {
    RUN_STOPPED = 2'd0,
    RUN_RUNNING = 2'd1,
    RUN_PAUSED  = 2'd2
  } run_t;

  typedef enum logic [1:0] {
    PH_WORK  = 2'd0,
    PH_SHORT = 2'd1,
    PH_LONG  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_TOGGLE = 3'd1,
    REQ_SKIP   = 3'd2,
    REQ_RESET  = 3'd3,
    REQ_EXTEND = 3'd4
  } req_t;

  cfg_t cfg;

  pptmr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic        s1_valid_r;
  logic [2:0]  s1_req_r;
  logic [15:0] s1_ext_r;
  logic        advance;

  // timer state
  run_t        run_r, run_nxt;
  phase_t      phase_r, phase_nxt;
  time_t       left_r, left_nxt;
  time_t       len_r, len_nxt;
  logic [15:0] count_r, count_nxt;
  logic [3:0]  pos_r, pos_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  fin_phase_r, fin_phase_nxt;
  logic [15:0] fin_secs_r, fin_secs_nxt;
  logic        fin_r, fin_nxt;
  logic        fin_work_r, fin_work_nxt;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // update logic
  time_t               left_dec;
  time_t               cur_len;
  time_t               skip_len;
  logic [3:0]          pos_inc;
  logic [15:0]         ext_eff;
  logic [TIME_BITS:0]  len_sum;
  logic [TIME_BITS:0]  left_sum;
  phase_t              done_next;

  always_comb begin
    left_dec  = left_r - time_t'(left_r != '0);
    pos_inc   = pos_r + 4'd1;
    ext_eff   = (s1_ext_r == 16'd0) ? 16'd1 : s1_ext_r;
    len_sum   = (TIME_BITS+1)'(len_r) + (TIME_BITS+1)'(ext_eff);
    left_sum  = (TIME_BITS+1)'(left_r) + (TIME_BITS+1)'(ext_eff);
    case (phase_r)
      PH_SHORT: cur_len = min_to_sec(cfg.short_min);
      PH_LONG:  cur_len = min_to_sec(cfg.long_min);
      default:  cur_len = min_to_sec(cfg.work_min);
    endcase
    skip_len = (phase_r == PH_WORK) ? min_to_sec(cfg.short_min) : min_to_sec(cfg.work_min);
    if (phase_r != PH_WORK) begin
      done_next = PH_WORK;
    end else if (pos_inc >= cfg.long_after) begin
      done_next = PH_LONG;
    end else begin
      done_next = PH_SHORT;
    end

    run_nxt       = run_r;
    phase_nxt     = phase_r;
    left_nxt      = left_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    fin_nxt       = 1'b0;
    fin_phase_nxt = 2'd0;
    fin_secs_nxt  = 16'd0;
    fin_work_nxt  = 1'b0;

    if (cfg.local_mode) begin
      case (s1_req_r)
        REQ_TICK: begin
          if (run_r == RUN_RUNNING) begin
            left_nxt = left_dec;
            if (left_dec == '0) begin
              fin_nxt       = 1'b1;
              fin_phase_nxt = phase_r;
              fin_secs_nxt  = clip16(len_r);
              fin_work_nxt  = (phase_r == PH_WORK);
              run_nxt       = RUN_STOPPED;
              phase_nxt     = done_next;
              if (phase_r == PH_WORK) begin
                count_nxt = count_r + 16'd1;
                pos_nxt   = (done_next == PH_LONG) ? 4'd0 : pos_inc;
              end
              case (done_next)
                PH_SHORT: len_nxt = min_to_sec(cfg.short_min);
                PH_LONG:  len_nxt = min_to_sec(cfg.long_min);
                default:  len_nxt = min_to_sec(cfg.work_min);
              endcase
              left_nxt = len_nxt;
            end
          end
        end
        REQ_TOGGLE: begin
          if (run_r == RUN_RUNNING) begin
            run_nxt = RUN_PAUSED;
          end else begin
            if (left_r == '0) begin
              len_nxt  = cur_len;
              left_nxt = cur_len;
            end
            run_nxt = RUN_RUNNING;
          end
        end
        REQ_SKIP: begin
          phase_nxt = (phase_r == PH_WORK) ? PH_SHORT : PH_WORK;
          len_nxt   = skip_len;
          left_nxt  = skip_len;
          run_nxt   = RUN_STOPPED;
        end
        REQ_RESET: begin
          len_nxt  = cur_len;
          left_nxt = cur_len;
          run_nxt  = RUN_STOPPED;
        end
        REQ_EXTEND: begin
          if (run_r == RUN_RUNNING) begin
            len_nxt  = len_sum[TIME_BITS] ? '1 : len_sum[TIME_BITS-1:0];
            left_nxt = left_sum[TIME_BITS] ? '1 : left_sum[TIME_BITS-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= RUN_STOPPED;
      phase_r     <= PH_WORK;
      left_r      <= min_to_sec(WORK_MIN_RST);
      len_r       <= min_to_sec(WORK_MIN_RST);
      count_r     <= 16'd0;
      pos_r       <= 4'd0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
        s1_req_r   <= in_req_type;
        s1_ext_r   <= in_extend_seconds;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        run_r       <= run_nxt;
        phase_r     <= phase_nxt;
        left_r      <= left_nxt;
        len_r       <= len_nxt;
        count_r     <= count_nxt;
        pos_r       <= pos_nxt;
        fin_r       <= fin_nxt;
        fin_phase_r <= fin_phase_nxt;
        fin_secs_r  <= fin_secs_nxt;
        fin_work_r  <= fin_work_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_run_state         = run_r;
  assign out_phase_now         = phase_r;
  assign out_seconds_shown     = clip16(left_r);
  assign out_work_done_count   = count_r;
  assign out_phase_finished    = fin_r;
  assign out_finished_phase    = fin_phase_r;
  assign out_finished_seconds  = fin_secs_r;
  assign out_finished_was_work = fin_work_r;

endmodule
